@@ sv/daily_light_timer_with_buttons_macros.svh @@
// Assertion macros for the daily light timer RTL.
`ifndef DAILY_LIGHT_TIMER_WITH_BUTTONS_MACROS_SVH
`define DAILY_LIGHT_TIMER_WITH_BUTTONS_MACROS_SVH

`ifndef SYNTH
`define DLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("daily light timer check failed");
`define DLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("daily light timer check failed");
`else
`define DLT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/dlt_pkg.sv @@
package dlt_pkg;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE_MS   = 3'd0,
        CFG_ON_TIME_MODE0 = 3'd1,
        CFG_ON_TIME_MODE1 = 3'd2,
        CFG_ON_TIME_MODE2 = 3'd3,
        CFG_REPEAT_PERIOD = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic elapsed;
        logic released;
    } t_btn_evt;

    localparam logic [15:0] DEBOUNCE_RESET      = 16'd50;
    localparam logic [19:0] ON_TIME_MODE0_RESET = 20'd10800;
    localparam logic [19:0] ON_TIME_MODE1_RESET = 20'd32400;
    localparam logic [19:0] ON_TIME_MODE2_RESET = 20'd43200;
    localparam logic [19:0] REPEAT_RESET        = 20'd86400;

    localparam logic [2:0] MODE_NONE  = 3'd7;
    localparam logic [2:0] MODE_FIRST = 3'd0;
    localparam logic [1:0] MODE_SHORT = 2'd0;
    localparam logic [1:0] MODE_MID   = 2'd1;
    localparam logic [1:0] MODE_LONG  = 2'd2;
    localparam logic [1:0] MODE_DARK  = 2'd3;

    localparam logic [7:0] BRIGHT_RESET     = 8'd200;
    localparam logic [7:0] BRIGHT_LOW       = 8'd10;
    localparam logic [7:0] BRIGHT_MID       = 8'd100;
    localparam logic [7:0] BRIGHT_HIGH      = 8'd255;
    localparam logic [1:0] BRIGHT_IDX_FIRST = 2'd0;
    localparam logic [1:0] BRIGHT_IDX_MID   = 2'd1;
    localparam logic [1:0] BRIGHT_IDX_LAST  = 2'd2;

    function automatic logic [7:0] bright_value_of(input logic [1:0] idx,
                                                   input logic [7:0] cur);
        logic [7:0] v;
        case (idx)
            BRIGHT_IDX_FIRST: v = BRIGHT_LOW;
            BRIGHT_IDX_MID:   v = BRIGHT_MID;
            BRIGHT_IDX_LAST:  v = BRIGHT_HIGH;
            default:          v = cur;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] bright_idx_next(input logic [1:0] idx);
        logic [1:0] n;
        case (idx)
            BRIGHT_IDX_FIRST: n = BRIGHT_IDX_MID;
            BRIGHT_IDX_MID:   n = BRIGHT_IDX_LAST;
            BRIGHT_IDX_LAST:  n = BRIGHT_IDX_FIRST;
            default:          n = BRIGHT_IDX_MID;
        endcase
        return n;
    endfunction

endpackage

@@ sv/dlt_debounce.sv @@
module dlt_debounce
    import dlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_commit,
    input  logic [31:0] i_ms,
    input  logic        i_level,
    input  logic [15:0] i_debounce_ms,
    output t_btn_evt    o_evt
);

    logic        r_last_level;
    logic [31:0] r_last_change;
    logic        n_last_level;
    logic [31:0] n_last_change;
    logic [31:0] elapsed_ms;
    logic        changed;

    assign elapsed_ms = i_ms - r_last_change;
    assign o_evt.elapsed = elapsed_ms > {16'd0, i_debounce_ms};
    assign changed = o_evt.elapsed && (i_level != r_last_level);
    assign o_evt.released = changed && !i_level;

    always_comb begin
        n_last_level  = r_last_level;
        n_last_change = r_last_change;
        if (changed) begin
            n_last_level  = i_level;
            n_last_change = i_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level  <= 1'b0;
            r_last_change <= '0;
        end else if (i_commit) begin
            r_last_level  <= n_last_level;
            r_last_change <= n_last_change;
        end
    end

endmodule

@@ sv/daily_light_timer_with_buttons.sv @@
// An accepted input beat is registered in the input stage, and its result in the output stage.
// Throughput: one polling pass per cycle while the output is not stalled; the pass is
// computed between the input stage register and the state and result registers.
// Reset (synchronous, active low) empties both stages, restores the register
// defaults, sets brightness 200, no mode chosen and the lamp dark.
`include "daily_light_timer_with_buttons_macros.svh"

module daily_light_timer_with_buttons
    import dlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_ms_time,
    input  logic [31:0] i_clock_seconds,
    input  logic        i_bright_button,
    input  logic        i_power_button,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_light_on,
    output logic [7:0]  o_brightness_level,
    output logic [1:0]  o_mode_value,
    output logic        o_mode_chosen
);

    logic [15:0] r_debounce_ms;
    logic [19:0] r_on_time0;
    logic [19:0] r_on_time1;
    logic [19:0] r_on_time2;
    logic [19:0] r_repeat;

    logic        r_in_valid;
    logic [31:0] r_in_ms;
    logic [31:0] r_in_now;
    logic        r_in_bright;
    logic        r_in_power;
    logic        r_out_valid;

    logic [1:0]  r_bidx;
    logic [7:0]  r_bval;
    logic [2:0]  r_mode;
    logic [31:0] r_deadline;
    logic [31:0] r_retrig;
    logic        r_lamp;

    logic [1:0]  n_bidx;
    logic [7:0]  n_bval;
    logic [2:0]  n_mode;
    logic [31:0] n_deadline;
    logic [31:0] n_retrig;
    logic        n_lamp;

    logic        out_free;
    logic        commit;
    logic        trigger;
    logic [19:0] span;
    t_btn_evt    bright_evt;
    t_btn_evt    power_evt;

    assign out_free = !r_out_valid || !i_stall;
    assign commit   = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
            r_on_time0    <= ON_TIME_MODE0_RESET;
            r_on_time1    <= ON_TIME_MODE1_RESET;
            r_on_time2    <= ON_TIME_MODE2_RESET;
            r_repeat      <= REPEAT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:   r_debounce_ms <= i_cfg_data[15:0];
                CFG_ON_TIME_MODE0: r_on_time0    <= i_cfg_data;
                CFG_ON_TIME_MODE1: r_on_time1    <= i_cfg_data;
                CFG_ON_TIME_MODE2: r_on_time2    <= i_cfg_data;
                CFG_REPEAT_PERIOD: r_repeat      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_ms     <= i_ms_time;
            r_in_now    <= i_clock_seconds;
            r_in_bright <= i_bright_button;
            r_in_power  <= i_power_button;
        end
    end

    dlt_debounce u_bright_db (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (commit),
        .i_ms          (r_in_ms),
        .i_level       (r_in_bright),
        .i_debounce_ms (r_debounce_ms),
        .o_evt         (bright_evt)
    );

    dlt_debounce u_power_db (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (commit),
        .i_ms          (r_in_ms),
        .i_level       (r_in_power),
        .i_debounce_ms (r_debounce_ms),
        .o_evt         (power_evt)
    );

    always_comb begin
        n_bidx     = r_bidx;
        n_bval     = r_bval;
        n_mode     = r_mode;
        n_deadline = r_deadline;
        n_retrig   = r_retrig;
        n_lamp     = r_lamp;
        trigger    = 1'b0;
        span       = r_on_time0;

        if (r_retrig != '0 && r_in_now >= r_retrig) begin
            trigger  = 1'b1;
            n_retrig = '0;
        end

        if (bright_evt.released) begin
            n_bval = bright_value_of(r_bidx, r_bval);
            n_bidx = bright_idx_next(r_bidx);
        end

        if (power_evt.released) begin
            n_mode  = r_mode[2] ? MODE_FIRST : {1'b0, 2'(r_mode[1:0] + 2'd1)};
            trigger = 1'b1;
        end

        // The lamp only expires in a pass where the power window is open.
        if (power_evt.elapsed && r_in_now >= r_deadline) begin
            n_lamp = 1'b0;
        end

        if (trigger && !n_mode[2]) begin
            case (n_mode[1:0])
                MODE_SHORT: span = r_on_time0;
                MODE_MID:   span = r_on_time1;
                MODE_LONG:  span = r_on_time2;
                default:    span = r_on_time0;
            endcase
            if (n_mode[1:0] == MODE_DARK) begin
                n_lamp = 1'b0;
            end else begin
                n_lamp     = 1'b1;
                n_deadline = r_in_now + {12'd0, span};
                n_retrig   = r_in_now + {12'd0, r_repeat};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidx     <= BRIGHT_IDX_FIRST;
            r_bval     <= BRIGHT_RESET;
            r_mode     <= MODE_NONE;
            r_deadline <= '0;
            r_retrig   <= '0;
            r_lamp     <= 1'b0;
        end else if (commit) begin
            r_bidx     <= n_bidx;
            r_bval     <= n_bval;
            r_mode     <= n_mode;
            r_deadline <= n_deadline;
            r_retrig   <= n_retrig;
            r_lamp     <= n_lamp;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_light_on         = r_lamp;
    assign o_brightness_level = r_bval;
    assign o_mode_value       = r_mode[2] ? 2'd0 : r_mode[1:0];
    assign o_mode_chosen      = !r_mode[2];

    `DLT_ASSERT_NEXT(a_stage_held, i_clk, i_rst_n, o_stall, r_in_valid)
    `DLT_ASSERT_NEXT(a_mode_sticky, i_clk, i_rst_n, !r_mode[2], !r_mode[2])
    `DLT_ASSERT_NOW(a_bidx_range, i_clk, i_rst_n, 1'b1, r_bidx <= BRIGHT_IDX_LAST)
    `DLT_ASSERT_NOW(a_lit_has_mode, i_clk, i_rst_n, r_lamp, !r_mode[2] && r_mode[1:0] != MODE_DARK)

endmodule
